FILE: rtl/core/pending_verdict_table_macros.svh
// Assertion macros for the pending verdict table core.
// Included by the top level; no other dependencies.
`ifndef PENDING_VERDICT_TABLE_MACROS_SVH
`define PENDING_VERDICT_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define PVT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define PVT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PVT_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define PVT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/pvt_pkg.sv
// Package for the pending verdict table: beat types, codes and constants.
// Used by every module of the core.
`timescale 1ns / 1ps
package pvt_pkg;
   localparam int unsigned TableDepth = 32;
   localparam int unsigned MaxResults = 32;
   localparam logic [15:0] StaleReset = 16'd300;
   localparam logic [15:0] AgeMax = 16'hFFFF;

   localparam logic [1:0] REQ_LOOKUP = 2'd0;
   localparam logic [1:0] REQ_TICK = 2'd1;
   localparam logic [1:0] REQ_VERDICT = 2'd2;
   localparam logic [1:0] REQ_CLEAR = 2'd3;

   localparam logic [1:0] KIND_PROCEED = 2'd0;
   localparam logic [1:0] KIND_BLOCK = 2'd1;
   localparam logic [1:0] KIND_STALL = 2'd2;
   localparam logic [1:0] KIND_DISPATCH = 2'd3;

   localparam logic [1:0] ST_PENDING = 2'd0;
   localparam logic [1:0] ST_INFLIGHT = 2'd1;
   localparam logic [1:0] ST_ALLOWED = 2'd2;
   localparam logic [1:0] ST_DENIED = 2'd3;

   localparam logic [1:0] VERD_ALLOW = 2'd0;
   localparam logic [1:0] VERD_DENY = 2'd1;
   localparam logic [1:0] VERD_GONE = 2'd2;

   typedef struct packed {
      logic [1:0] req_type;
      logic [31:0] actor_key;
      logic [31:0] proposed_id;
      logic [31:0] current_id;
      logic [1:0] verdict_code;
   } req_beat_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [31:0] out_key;
      logic [31:0] out_proposed;
      logic [31:0] out_current;
      logic last_flag;
   } rsp_beat_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // capture the accepted beat, reset the cursor
      logic rd;        // issue a read of the cursor entry
      logic step;      // advance the cursor
      logic wr_new;    // append the beat as a new pending entry
      logic wr_requeue; // rewrite the cursor entry from the beat
      logic wr_status; // write the given status to the cursor entry
      logic [1:0] status;
      logic wr_age;    // write the aged value to the cursor entry
      logic erase_rd;  // read the last entry for a move
      logic erase_wr;  // move the read last entry into the cursor slot
      logic clear;
      logic emit;      // load output register
      logic [1:0] kind;
      logic emit_rec;  // output carries the entry fields
      logic last;
   } pvt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic at_end;    // cursor has reached the fill count
      logic full;
      logic key_hit;
      logic prop_eq;
      logic [1:0] status;
      logic stale;     // aged value beyond the limit
      logic rsp_busy;  // output register still holds a beat
   } pvt_sts_type;
endpackage

FILE: rtl/core/pending_verdict_table.sv
// Pending verdict table. A lookup or verdict scans the table entry by entry, reading and then
// checking each; a tick walks all entries, ageing each and moving the last entry over each drop.
// One item is worked at a time; the output stage may hold one result while the next starts.
// Synchronous active-high reset empties the table and sets stale_limit to 300.
// Depends on pvt_pkg, pvt_control, pvt_datapath, pvt_last.
`timescale 1ns / 1ps
`include "pending_verdict_table_macros.svh"
module pending_verdict_table #(
   parameter int unsigned TABLE_DEPTH = pvt_pkg::TableDepth
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input pvt_pkg::req_beat_type req_beat,
   output logic rsp_valid,
   input logic rsp_stall,
   output pvt_pkg::rsp_beat_type rsp_beat,
   input logic csr_valid,
   output logic csr_ready,
   input logic [15:0] csr_data
);
   logic [15:0] stale_limit_ff;
   pvt_pkg::pvt_cmd_type cmd;
   pvt_pkg::pvt_sts_type sts;
   logic mid_valid, mid_stall;
   pvt_pkg::rsp_beat_type mid_beat;
   logic walk_done, ctrl_stall, ctrl_valid, hold_busy;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stale_limit_ff <= pvt_pkg::StaleReset;
      end else if (csr_valid && csr_ready) begin
         stale_limit_ff <= csr_data;
      end
   end

   // A new item waits until the previous results have left the datapath and the marker.
   assign ctrl_valid = req_valid && !mid_valid && !hold_busy;
   assign req_stall = ctrl_stall || mid_valid || hold_busy;

   pvt_control u_control (
      .clock(clock), .reset(reset),
      .req_valid(ctrl_valid), .req_stall(ctrl_stall),
      .req_type(req_beat.req_type), .verdict_code(req_beat.verdict_code),
      .sts(sts), .cmd(cmd)
   );

   pvt_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_datapath (
      .clock(clock), .reset(reset), .req_beat(req_beat),
      .stale_limit(stale_limit_ff), .cmd(cmd), .sts(sts),
      .rsp_valid(mid_valid), .rsp_stall(mid_stall), .rsp_beat(mid_beat)
   );

   // The walk is over once the controller is back to taking items and nothing waits.
   assign walk_done = !ctrl_stall && !mid_valid;

   pvt_last u_last (
      .clock(clock), .reset(reset), .walk_done(walk_done),
      .in_valid(mid_valid), .in_stall(mid_stall), .in_beat(mid_beat),
      .hold_busy(hold_busy),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_beat(rsp_beat)
   );

   `PVT_ASSERT_NEXT(a_clear_empties, clock, reset,
      req_valid && !req_stall && req_beat.req_type == pvt_pkg::REQ_CLEAR,
      sts.at_end)
   `PVT_ASSERT_IMPL(a_no_accept_busy, clock, reset, sts.rsp_busy, req_stall)
   `PVT_ASSERT_IMPL(a_emit_free, clock, reset, cmd.emit, !sts.rsp_busy)
endmodule

FILE: rtl/core/pvt_datapath.sv
// Datapath of the pending verdict table: entry memory, cursor, fill count, output register.
// Depends on pvt_pkg.
`timescale 1ns / 1ps
module pvt_datapath #(
   parameter int unsigned TABLE_DEPTH = pvt_pkg::TableDepth
) (
   input logic clock,
   input logic reset,
   input pvt_pkg::req_beat_type req_beat,
   input logic [15:0] stale_limit,
   input pvt_pkg::pvt_cmd_type cmd,
   output pvt_pkg::pvt_sts_type sts,
   output logic rsp_valid,
   input logic rsp_stall,
   output pvt_pkg::rsp_beat_type rsp_beat
);
   localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] prop;
      logic [31:0] cur;
      logic [15:0] age;
      logic [1:0] status;
   } entry_type;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_ff;
   pvt_pkg::req_beat_type beat_ff;
   logic [CntW-1:0] cur_ff, cur_in, cnt_ff, cnt_in;
   logic rsp_valid_ff;
   pvt_pkg::rsp_beat_type rsp_ff;
   logic [15:0] aged;
   logic [IdxW-1:0] rd_addr, wr_addr;
   logic wr_en;
   entry_type wr_data;
   logic [CntW-1:0] last_idx;

   assign last_idx = cnt_ff - CntW'(1);
   assign aged = (rd_ff.age == pvt_pkg::AgeMax) ? rd_ff.age : rd_ff.age + 16'd1;

   always_comb begin
      rd_addr = cmd.erase_rd ? last_idx[IdxW-1:0] : cur_ff[IdxW-1:0];
      wr_en = 1'b0;
      wr_addr = cur_ff[IdxW-1:0];
      wr_data = rd_ff;
      if (cmd.wr_new) begin
         wr_en = 1'b1;
         wr_addr = cnt_ff[IdxW-1:0];
         wr_data = '{beat_ff.actor_key, beat_ff.proposed_id, beat_ff.current_id,
                     16'd0, pvt_pkg::ST_PENDING};
      end else if (cmd.wr_requeue) begin
         wr_en = 1'b1;
         wr_data = '{rd_ff.key, beat_ff.proposed_id, beat_ff.current_id,
                     16'd0, pvt_pkg::ST_PENDING};
      end else if (cmd.wr_age || cmd.wr_status) begin
         wr_en = 1'b1;
         wr_data.age = cmd.wr_age ? aged : rd_ff.age;
         wr_data.status = cmd.wr_status ? cmd.status : rd_ff.status;
      end else if (cmd.erase_wr) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd || cmd.erase_rd) begin
         rd_ff <= mem[rd_addr];
      end
      if (cmd.load) begin
         beat_ff <= req_beat;
      end
   end

   always_comb begin
      cur_in = cur_ff;
      if (cmd.load) begin
         cur_in = '0;
      end else if (cmd.step) begin
         cur_in = cur_ff + CntW'(1);
      end
      cnt_in = cnt_ff;
      if (cmd.clear) begin
         cnt_in = '0;
      end else if (cmd.wr_new) begin
         cnt_in = cnt_ff + CntW'(1);
      end else if (cmd.erase_rd) begin
         cnt_in = last_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_ff <= cur_in;
         cnt_ff <= cnt_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.result_kind <= cmd.kind;
         rsp_ff.out_key <= cmd.emit_rec ? rd_ff.key : 32'd0;
         rsp_ff.out_proposed <= cmd.emit_rec ? rd_ff.prop : 32'd0;
         rsp_ff.out_current <= cmd.emit_rec ? rd_ff.cur : 32'd0;
         rsp_ff.last_flag <= cmd.last;
      end
   end

   always_comb begin
      sts.at_end = (cur_ff >= cnt_ff);
      sts.full = (cnt_ff == CntW'(TABLE_DEPTH));
      sts.key_hit = (rd_ff.key == beat_ff.actor_key);
      sts.prop_eq = (rd_ff.prop == beat_ff.proposed_id);
      sts.status = rd_ff.status;
      sts.stale = (aged > stale_limit);
      sts.rsp_busy = rsp_valid_ff && rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat = rsp_ff;
endmodule

FILE: rtl/core/pvt_control.sv
// Controller of the pending verdict table: sequences lookups, tick walks and verdicts.
// Depends on pvt_pkg.
`timescale 1ns / 1ps
module pvt_control (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [1:0] req_type,
   input logic [1:0] verdict_code,
   input pvt_pkg::pvt_sts_type sts,
   output pvt_pkg::pvt_cmd_type cmd
);
   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001,
      S_READ = 8'b00000010,
      S_CHECK = 8'b00000100,
      S_ERASE = 8'b00001000,
      S_MOVE = 8'b00010000,
      S_TREAD = 8'b00100000,
      S_TCHECK = 8'b01000000,
      S_WAIT = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] type_ff, code_ff, kind_ff, kind_in;
   logic [5:0] nrec_ff, nrec_in;
   logic tick_ff, tick_in;

   logic is_pend, cap_ok, pend_emit;

   assign is_pend = (sts.status == pvt_pkg::ST_PENDING);
   assign cap_ok = (nrec_ff < 6'(pvt_pkg::MaxResults));

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      nrec_in = nrec_ff;
      tick_in = tick_ff;
      cmd = '0;
      req_stall = 1'b1;
      pend_emit = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = sts.rsp_busy;
            if (req_valid && !sts.rsp_busy) begin
               cmd.load = 1'b1;
               nrec_in = '0;
               tick_in = 1'b0;
               unique case (req_type)
                  pvt_pkg::REQ_CLEAR: cmd.clear = 1'b1;
                  pvt_pkg::REQ_TICK: state_in = S_TREAD;
                  default: state_in = S_READ;
               endcase
            end
         end
         S_READ: begin
            if (sts.at_end) begin
               if (type_ff == pvt_pkg::REQ_LOOKUP) begin
                  kind_in = sts.full ? pvt_pkg::KIND_PROCEED : pvt_pkg::KIND_STALL;
                  cmd.wr_new = !sts.full;
                  state_in = S_WAIT;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               cmd.rd = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!sts.key_hit) begin
               cmd.step = 1'b1;
               state_in = S_READ;
            end else if (type_ff == pvt_pkg::REQ_LOOKUP) begin
               kind_in = pvt_pkg::KIND_STALL;
               state_in = S_WAIT;
               if (sts.status == pvt_pkg::ST_ALLOWED) begin
                  kind_in = pvt_pkg::KIND_PROCEED;
                  state_in = S_ERASE;
               end else if (sts.status == pvt_pkg::ST_DENIED) begin
                  kind_in = pvt_pkg::KIND_BLOCK;
                  state_in = S_ERASE;
               end else if (!sts.prop_eq) begin
                  cmd.wr_requeue = 1'b1;
               end
            end else begin
               state_in = S_IDLE;
               if (sts.status == pvt_pkg::ST_INFLIGHT && sts.prop_eq) begin
                  case (code_ff)
                     pvt_pkg::VERD_ALLOW: begin
                        cmd.wr_status = 1'b1;
                        cmd.status = pvt_pkg::ST_ALLOWED;
                     end
                     pvt_pkg::VERD_DENY: begin
                        cmd.wr_status = 1'b1;
                        cmd.status = pvt_pkg::ST_DENIED;
                     end
                     pvt_pkg::VERD_GONE: state_in = S_ERASE;
                     default: ;
                  endcase
               end
            end
         end
         S_ERASE: begin
            cmd.erase_rd = 1'b1;
            state_in = S_MOVE;
         end
         S_MOVE: begin
            cmd.erase_wr = 1'b1;
            if (tick_ff) begin
               state_in = S_TREAD;
            end else if (type_ff == pvt_pkg::REQ_LOOKUP) begin
               state_in = S_WAIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_TREAD: begin
            if (sts.at_end) begin
               state_in = S_IDLE;
            end else begin
               cmd.rd = 1'b1;
               state_in = S_TCHECK;
            end
         end
         S_TCHECK: begin
            // Walk one entry: age it, drop it when stale, else dispatch it if pending and below the result cap.
            if (sts.stale) begin
               tick_in = 1'b1;
               state_in = S_ERASE;
            end else begin
               pend_emit = is_pend && cap_ok;
               if (pend_emit && sts.rsp_busy) begin
                  state_in = S_TCHECK;
               end else begin
                  cmd.wr_age = 1'b1;
                  cmd.wr_status = pend_emit;
                  cmd.status = pvt_pkg::ST_INFLIGHT;
                  cmd.step = 1'b1;
                  state_in = S_TREAD;
                  if (pend_emit) begin
                     cmd.emit = 1'b1;
                     cmd.emit_rec = 1'b1;
                     cmd.kind = pvt_pkg::KIND_DISPATCH;
                     nrec_in = nrec_ff + 6'd1;
                  end
               end
            end
         end
         S_WAIT: begin
            if (!sts.rsp_busy) begin
               cmd.emit = 1'b1;
               cmd.kind = kind_ff;
               cmd.last = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         type_ff <= pvt_pkg::REQ_LOOKUP;
         code_ff <= pvt_pkg::VERD_ALLOW;
         kind_ff <= pvt_pkg::KIND_PROCEED;
         nrec_ff <= '0;
         tick_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         kind_ff <= kind_in;
         nrec_ff <= nrec_in;
         tick_ff <= tick_in;
         if (cmd.load) begin
            type_ff <= req_type;
            code_ff <= verdict_code;
         end
      end
   end
endmodule

FILE: rtl/core/pvt_last.sv
// Last-record marker: holds the final dispatch of a tick until the walk ends.
// Depends on pvt_pkg.
`timescale 1ns / 1ps
module pvt_last (
   input logic clock,
   input logic reset,
   input logic walk_done,
   input logic in_valid,
   output logic in_stall,
   input pvt_pkg::rsp_beat_type in_beat,
   output logic hold_busy,
   output logic rsp_valid,
   input logic rsp_stall,
   output pvt_pkg::rsp_beat_type rsp_beat
);
   // One dispatch is held back so that its last flag can be set once the walk ends.
   logic hold_valid_ff, hold_valid_in;
   pvt_pkg::rsp_beat_type hold_ff;
   logic out_valid_ff;
   pvt_pkg::rsp_beat_type out_ff;
   logic out_free, take, push;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign push = hold_valid_ff && out_free &&
      ((in_valid && !in_stall) || walk_done);
   assign in_stall = !out_free &&
      (hold_valid_ff || in_beat.result_kind != pvt_pkg::KIND_DISPATCH);
   assign take = in_valid && !in_stall;
   assign hold_busy = hold_valid_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (push) begin
         hold_valid_in = 1'b0;
      end
      if (take && in_beat.result_kind == pvt_pkg::KIND_DISPATCH && !in_beat.last_flag) begin
         hold_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         if (push || (take && !(in_beat.result_kind == pvt_pkg::KIND_DISPATCH))) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && in_beat.result_kind == pvt_pkg::KIND_DISPATCH) begin
         hold_ff <= in_beat;
      end
      if (push) begin
         out_ff <= hold_ff;
         out_ff.last_flag <= walk_done && !(take);
      end else if (take && !(in_beat.result_kind == pvt_pkg::KIND_DISPATCH)) begin
         out_ff <= in_beat;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_beat = out_ff;
endmodule

FILE: test/testbench.sv
// Self-checking testbench for the pending verdict table, with a lookup/tick/verdict
// predictor kept alongside the block. Depends on pvt_pkg and pending_verdict_table.
`timescale 1ns / 1ps
module testbench;
   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall, csr_valid, csr_ready;
   pvt_pkg::req_beat_type req_beat;
   pvt_pkg::rsp_beat_type rsp_beat;
   logic [15:0] csr_data;

   pending_verdict_table u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_beat(req_beat),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_beat(rsp_beat),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   logic [31:0] tbl_key [pvt_pkg::TableDepth];
   logic [31:0] tbl_prop [pvt_pkg::TableDepth];
   logic [31:0] tbl_cur [pvt_pkg::TableDepth];
   logic [15:0] tbl_age [pvt_pkg::TableDepth];
   logic [1:0] tbl_status [pvt_pkg::TableDepth];
   int unsigned tbl_fill = 0;
   logic [15:0] age_limit = pvt_pkg::StaleReset;

   pvt_pkg::req_beat_type beats_waiting[$];
   pvt_pkg::rsp_beat_type verdicts_due[$];
   logic [31:0] key_pool [40];
   logic [31:0] prop_pool [40];
   logic calm;
   int unsigned mismatches = 0;
   int unsigned beats_sent = 0;
   int unsigned answers_seen = 0;
   int unsigned dispatches_seen = 0;
   int unsigned cycle_count = 0;
   int unsigned req_gap, rsp_gap;

   function automatic int find_key(logic [31:0] key);
      for (int i = 0; i < tbl_fill; i++)
         if (tbl_key[i] == key) return i;
      return -1;
   endfunction

   function automatic void drop_slot(int i);
      int unsigned tail;
      tail = tbl_fill - 1;
      tbl_key[i] = tbl_key[tail];
      tbl_prop[i] = tbl_prop[tail];
      tbl_cur[i] = tbl_cur[tail];
      tbl_age[i] = tbl_age[tail];
      tbl_status[i] = tbl_status[tail];
      tbl_fill = tail;
   endfunction

   function automatic void expect_answer(logic [1:0] kind);
      pvt_pkg::rsp_beat_type r;
      r = '0;
      r.result_kind = kind;
      r.last_flag = 1'b1;
      verdicts_due.push_back(r);
   endfunction

   function automatic void apply_beat(pvt_pkg::req_beat_type b);
      int s;
      int i;
      pvt_pkg::rsp_beat_type recs[$];
      pvt_pkg::rsp_beat_type r;
      case (b.req_type)
         pvt_pkg::REQ_LOOKUP: begin
            s = find_key(b.actor_key);
            if (s < 0) begin
               if (tbl_fill < pvt_pkg::TableDepth) begin
                  tbl_key[tbl_fill] = b.actor_key;
                  tbl_prop[tbl_fill] = b.proposed_id;
                  tbl_cur[tbl_fill] = b.current_id;
                  tbl_age[tbl_fill] = '0;
                  tbl_status[tbl_fill] = pvt_pkg::ST_PENDING;
                  tbl_fill++;
                  expect_answer(pvt_pkg::KIND_STALL);
               end else begin
                  expect_answer(pvt_pkg::KIND_PROCEED);
               end
            end else if (tbl_status[s] == pvt_pkg::ST_ALLOWED) begin
               drop_slot(s);
               expect_answer(pvt_pkg::KIND_PROCEED);
            end else if (tbl_status[s] == pvt_pkg::ST_DENIED) begin
               drop_slot(s);
               expect_answer(pvt_pkg::KIND_BLOCK);
            end else begin
               if (tbl_prop[s] != b.proposed_id) begin
                  tbl_prop[s] = b.proposed_id;
                  tbl_cur[s] = b.current_id;
                  tbl_age[s] = '0;
                  tbl_status[s] = pvt_pkg::ST_PENDING;
               end
               expect_answer(pvt_pkg::KIND_STALL);
            end
         end
         pvt_pkg::REQ_TICK: begin
            i = 0;
            while (i < tbl_fill) begin
               if (tbl_age[i] != pvt_pkg::AgeMax) tbl_age[i] = tbl_age[i] + 16'd1;
               if (tbl_age[i] > age_limit) begin
                  drop_slot(i);
                  continue;
               end
               if (tbl_status[i] == pvt_pkg::ST_PENDING && recs.size() < pvt_pkg::MaxResults) begin
                  tbl_status[i] = pvt_pkg::ST_INFLIGHT;
                  r.result_kind = pvt_pkg::KIND_DISPATCH;
                  r.out_key = tbl_key[i];
                  r.out_proposed = tbl_prop[i];
                  r.out_current = tbl_cur[i];
                  r.last_flag = 1'b0;
                  recs.push_back(r);
               end
               i++;
            end
            if (recs.size() > 0) recs[recs.size() - 1].last_flag = 1'b1;
            foreach (recs[k]) verdicts_due.push_back(recs[k]);
         end
         pvt_pkg::REQ_VERDICT: begin
            s = find_key(b.actor_key);
            if (s >= 0 && tbl_status[s] == pvt_pkg::ST_INFLIGHT &&
                tbl_prop[s] == b.proposed_id) begin
               if (b.verdict_code == pvt_pkg::VERD_GONE) drop_slot(s);
               else if (b.verdict_code == pvt_pkg::VERD_ALLOW)
                  tbl_status[s] = pvt_pkg::ST_ALLOWED;
               else if (b.verdict_code == pvt_pkg::VERD_DENY)
                  tbl_status[s] = pvt_pkg::ST_DENIED;
            end
         end
         default: tbl_fill = 0;
      endcase
   endfunction

   function automatic void queue_beat(logic [1:0] kind, logic [31:0] key, logic [31:0] prop,
                                      logic [1:0] code);
      pvt_pkg::req_beat_type b;
      b.req_type = kind;
      b.actor_key = key;
      b.proposed_id = prop;
      b.current_id = $urandom;
      b.verdict_code = code;
      beats_waiting.push_back(b);
   endfunction

   function automatic void queue_random(int n, int lookup_pct);
      int p;
      int roll;
      logic [31:0] prop;
      for (int k = 0; k < n; k++) begin
         p = $urandom_range(0, 39);
         prop = ($urandom_range(0, 3) == 0) ? 32'($urandom) : prop_pool[p];
         roll = $urandom_range(0, 99);
         if (roll < lookup_pct)
            queue_beat(pvt_pkg::REQ_LOOKUP, key_pool[p], prop, 2'($urandom));
         else if (roll < lookup_pct + 15)
            queue_beat(pvt_pkg::REQ_TICK, 32'($urandom), 32'($urandom), 2'($urandom));
         else if (roll < 97)
            queue_beat(pvt_pkg::REQ_VERDICT, key_pool[p],
                       ($urandom_range(0, 5) == 0) ? 32'($urandom) : prop_pool[p],
                       ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2)));
         else
            queue_beat(pvt_pkg::REQ_CLEAR, 32'($urandom), 32'($urandom), 2'($urandom));
      end
   endfunction

   task automatic settle();
      while (beats_waiting.size() != 0 || req_valid || verdicts_due.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_limit(logic [15:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      age_limit = value;
   endtask

   always @(posedge clock) begin
      int unsigned wait_n;
      if (reset) begin
         req_valid <= 1'b0;
         req_beat <= '0;
         req_gap <= 0;
      end else begin
         wait_n = req_gap;
         if (req_valid && !req_stall) begin
            apply_beat(req_beat);
            beats_sent++;
            wait_n = calm ? 0 : $urandom_range(0, 9);
         end
         if (!req_valid || !req_stall) begin
            if (wait_n == 0 && beats_waiting.size() != 0) begin
               req_beat <= beats_waiting.pop_front();
               req_valid <= 1'b1;
               req_gap <= 0;
            end else begin
               req_valid <= 1'b0;
               req_gap <= (wait_n > 0) ? wait_n - 1 : 0;
            end
         end
      end
   end

   always @(posedge clock) begin
      int unsigned wait_n;
      pvt_pkg::rsp_beat_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_gap <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (rsp_beat.result_kind == pvt_pkg::KIND_DISPATCH) dispatches_seen++;
            else answers_seen++;
            if (verdicts_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected result beat %h", rsp_beat);
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_beat.result_kind !== want.result_kind ||
                   rsp_beat.out_key !== want.out_key ||
                   rsp_beat.out_proposed !== want.out_proposed ||
                   rsp_beat.out_current !== want.out_current ||
                   rsp_beat.last_flag !== want.last_flag) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: want %0d %h %h %h %b, got %0d %h %h %h %b",
                              want.result_kind, want.out_key, want.out_proposed,
                              want.out_current, want.last_flag, rsp_beat.result_kind,
                              rsp_beat.out_key, rsp_beat.out_proposed,
                              rsp_beat.out_current, rsp_beat.last_flag);
               end
            end
            wait_n = calm ? 0 : $urandom_range(0, 9);
         end else begin
            wait_n = (rsp_gap > 0) ? rsp_gap - 1 : 0;
         end
         rsp_gap <= wait_n;
         rsp_stall <= (wait_n != 0);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 1000000) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_data = '0;
      calm = 1'b0;
      key_pool[0] = 32'h0;
      key_pool[1] = 32'hFFFF_FFFF;
      prop_pool[0] = 32'h0;
      prop_pool[1] = 32'hFFFF_FFFF;
      for (int k = 2; k < 40; k++) begin
         key_pool[k] = $urandom;
         prop_pool[k] = $urandom;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      queue_beat(pvt_pkg::REQ_TICK, 32'd0, 32'd0, pvt_pkg::VERD_ALLOW);
      queue_beat(pvt_pkg::REQ_LOOKUP, 32'h0, 32'h0, pvt_pkg::VERD_ALLOW);
      queue_beat(pvt_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
      queue_beat(pvt_pkg::REQ_LOOKUP, 32'h0, 32'h0, pvt_pkg::VERD_ALLOW);
      queue_beat(pvt_pkg::REQ_TICK, 32'd0, 32'd0, pvt_pkg::VERD_ALLOW);
      queue_beat(pvt_pkg::REQ_LOOKUP, 32'h0, 32'h1234_5678, pvt_pkg::VERD_ALLOW);
      queue_beat(pvt_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, pvt_pkg::VERD_ALLOW);
      queue_beat(pvt_pkg::REQ_TICK, 32'd0, 32'd0, pvt_pkg::VERD_ALLOW);
      queue_beat(pvt_pkg::REQ_VERDICT, 32'h0, 32'h1234_5678, pvt_pkg::VERD_ALLOW);
      queue_beat(pvt_pkg::REQ_VERDICT, 32'hFFFF_FFFF, 32'hFFFF_FFFE, pvt_pkg::VERD_DENY);
      queue_beat(pvt_pkg::REQ_VERDICT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, pvt_pkg::VERD_DENY);
      queue_beat(pvt_pkg::REQ_VERDICT, 32'h5555_AAAA, 32'h0, pvt_pkg::VERD_ALLOW);
      queue_beat(pvt_pkg::REQ_LOOKUP, 32'h0, 32'h0, pvt_pkg::VERD_ALLOW);
      queue_beat(pvt_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0, pvt_pkg::VERD_ALLOW);
      queue_beat(pvt_pkg::REQ_TICK, 32'd0, 32'd0, pvt_pkg::VERD_ALLOW);
      queue_beat(pvt_pkg::REQ_LOOKUP, 32'hA5A5_5A5A, 32'h7, pvt_pkg::VERD_ALLOW);
      queue_beat(pvt_pkg::REQ_TICK, 32'd0, 32'd0, pvt_pkg::VERD_ALLOW);
      queue_beat(pvt_pkg::REQ_VERDICT, 32'hA5A5_5A5A, 32'h7, 2'd3);
      queue_beat(pvt_pkg::REQ_VERDICT, 32'hA5A5_5A5A, 32'h7, pvt_pkg::VERD_GONE);
      queue_beat(pvt_pkg::REQ_LOOKUP, 32'h1, 32'h1, pvt_pkg::VERD_ALLOW);
      queue_beat(pvt_pkg::REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
      queue_beat(pvt_pkg::REQ_LOOKUP, 32'h1, 32'h1, pvt_pkg::VERD_ALLOW);
      for (int k = 0; k < 34; k++)
         queue_beat(pvt_pkg::REQ_LOOKUP, 32'h100 + 32'(k), 32'($urandom),
                    pvt_pkg::VERD_ALLOW);
      queue_beat(pvt_pkg::REQ_TICK, 32'd0, 32'd0, pvt_pkg::VERD_ALLOW);

      write_limit(16'd1);
      queue_random(70, 50);
      write_limit(16'd65534);
      calm = 1'b1;
      queue_random(30, 65);
      settle();
      calm = 1'b0;
      queue_random(40, 45);
      write_limit(16'($urandom_range(2, 12)));
      queue_random(70, 45);
      settle();

      $display("Sent %0d request beats over four stale-limit settings.", beats_sent);
      $display("Checked %0d answers and %0d dispatch records.", answers_seen, dispatches_seen);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
